// File: rtl/fsubm_pkg.sv
// shared types and constants for the first substring match core
package fsubm_pkg;

    localparam int PAT_CHARS   = 16;   // characters held by the pattern registers
    localparam int LEN_W       = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int POS_W       = 17;   // signed match position
    localparam int POS_CAP_W   = 16;   // position limit never exceeds 65535
    localparam int M_TDATA_W   = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

    localparam logic [POS_W-1:0] NO_MATCH = {POS_W{1'b1}};

    // control handed from the sequencer to every cell
    typedef struct packed {
        logic shift;   // take the new prefix bit
        logic clear;   // text finished, drop all prefix bits
    } cell_ctrl_t;

endpackage

// File: rtl/fsubm_cell.sv
// one comparator cell of the prefix-match chain
module fsubm_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  fsubm_pkg::cell_ctrl_t ctrl,
    input  logic                active,      // cell lies inside the pattern length
    input  logic [7:0]          pat_char,
    input  logic [7:0]          text_byte,
    input  logic                prev_bit,    // neighbor's prefix bit, 1 for the first cell
    output logic                bit_next,
    output logic                bit_reg
);

    assign bit_next = active && prev_bit && (text_byte == pat_char);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= 1'b0;
        end else if (ctrl.clear) begin
            bit_reg <= 1'b0;
        end else if (ctrl.shift) begin
            bit_reg <= bit_next;
        end
    end

endmodule

// File: rtl/first_substring_match_core.sv
// Top level of the first substring match core. One text byte is taken per request on the
// s_ side, one request per clock while s_tready is high; s_tlast ends a text and s_tuser low
// marks an item with no character (a text of only such items is empty). A row of comparator
// cells (MAX_PATTERN of them, at most 16) holds the prefix-match bits, each cell passing its
// bit to the next on each accepted character until the result is given, so a match is known
// in the cycle its last byte is accepted and sits in the output register on the next clock.
// Each text gives one result on m_tdata: the zero-based start of the first occurrence, or -1
// if it ends without one; an empty pattern gives 0 on the first item. Positions count up to
// 2^POSITION_BITS - 1 (at most 65535), then stick and set m_tuser. The output register frees
// s_tready once m_tready takes the result. The user must write the pattern registers through
// cfg_we/cfg_index/cfg_wdata only while no text is in flight; the core does not enforce it.
module first_substring_match_core #(
    parameter int MAX_PATTERN   = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [fsubm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fsubm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] text_byte
    input  logic                                 s_tuser,   // [0] has_char
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [fsubm_pkg::M_TDATA_W-1:0]      m_tdata,   // [16:0] match_position
    output logic                                 m_tuser    // [0] position_saturated
);

    localparam int NCELL = (MAX_PATTERN < fsubm_pkg::PAT_CHARS) ? MAX_PATTERN
                                                               : fsubm_pkg::PAT_CHARS;
    localparam int CNT_W = (POSITION_BITS < fsubm_pkg::POS_CAP_W) ? POSITION_BITS
                                                                 : fsubm_pkg::POS_CAP_W;
    localparam int LW    = fsubm_pkg::LEN_W;
    localparam int PW    = fsubm_pkg::POS_W;

    logic [LW-1:0]     pat_len_reg;
    logic [63:0]       pat_low_reg;
    logic [63:0]       pat_high_reg;

    logic [CNT_W-1:0]  pos_reg,  pos_next;
    logic              started_reg, started_next;
    logic              given_reg,   given_next;
    logic              ovf_reg,     ovf_next;

    logic              m_valid_reg;
    logic [PW-1:0]     m_pos_reg;
    logic              m_sat_reg;

    logic [LW-1:0]     m_eff;
    logic              acc;
    fsubm_pkg::cell_ctrl_t ctrl;
    logic [NCELL-1:0]  bits_reg;
    logic [NCELL-1:0]  bits_next;
    logic [NCELL-1:0]  last_sel;
    logic              hit;
    logic              emit;
    logic [PW-1:0]     emit_pos;
    logic              emit_sat;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_len_reg  <= '0;
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                fsubm_pkg::REG_PATTERN_LENGTH: pat_len_reg  <= cfg_wdata[LW-1:0];
                fsubm_pkg::REG_PATTERN_LOW:    pat_low_reg  <= cfg_wdata;
                fsubm_pkg::REG_PATTERN_HIGH:   pat_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign m_eff    = (pat_len_reg > LW'(NCELL)) ? LW'(NCELL) : pat_len_reg;
    assign s_tready = !m_valid_reg || m_tready;
    assign acc      = s_tvalid && s_tready;

    assign ctrl.shift = acc && !given_reg && (m_eff != '0) && s_tuser;
    assign ctrl.clear = acc && s_tlast;

    // cell row
    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        logic [7:0] pat_char;
        logic       prev_bit;

        if (j < 8) begin : g_lo
            assign pat_char = pat_low_reg[8*j +: 8];
        end else begin : g_hi
            assign pat_char = pat_high_reg[8*(j-8) +: 8];
        end

        if (j == 0) begin : g_first
            assign prev_bit = 1'b1;
        end else begin : g_rest
            assign prev_bit = bits_reg[j-1];
        end

        assign last_sel[j] = (m_eff == LW'(j + 1));

        fsubm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .active    (LW'(j) < m_eff),
            .pat_char  (pat_char),
            .text_byte (s_tdata),
            .prev_bit  (prev_bit),
            .bit_next  (bits_next[j]),
            .bit_reg   (bits_reg[j])
        );
    end

    assign hit = |(bits_next & last_sel);

    // per-text sequencing and result selection
    always_comb begin
        logic [PW-1:0] idx;
        logic [PW-1:0] back;
        idx          = PW'(pos_reg);
        back         = PW'(m_eff) - PW'(1);
        pos_next     = pos_reg;
        started_next = 1'b1;
        given_next   = given_reg;
        ovf_next     = ovf_reg;
        emit         = 1'b0;
        emit_pos     = '0;
        if (!given_reg) begin
            if (m_eff == '0) begin
                if (!started_reg) begin
                    emit       = 1'b1;
                    given_next = 1'b1;
                end
            end else if (s_tuser) begin
                if (pos_reg == {CNT_W{1'b1}}) begin
                    ovf_next = 1'b1;
                end else begin
                    pos_next = pos_reg + CNT_W'(1);
                end
                if (hit) begin
                    emit       = 1'b1;
                    given_next = 1'b1;
                    emit_pos   = (idx >= back) ? (idx - back) : '0;
                end
            end
            if (s_tlast && !given_next) begin
                emit     = 1'b1;
                emit_pos = fsubm_pkg::NO_MATCH;
            end
        end
        emit_sat = ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            started_reg <= 1'b0;
            given_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
        end else if (acc) begin
            if (s_tlast) begin
                pos_reg     <= '0;
                started_reg <= 1'b0;
                given_reg   <= 1'b0;
                ovf_reg     <= 1'b0;
            end else begin
                pos_reg     <= pos_next;
                started_reg <= started_next;
                given_reg   <= given_next;
                ovf_reg     <= ovf_next;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (acc && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && emit) begin
            m_pos_reg <= emit_pos;
            m_sat_reg <= emit_sat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(fsubm_pkg::M_TDATA_W - PW){1'b0}}, m_pos_reg};
    assign m_tuser  = m_sat_reg;

`ifndef SYNTHESIS
    a_given_needs_start: assert property (@(posedge aclk) disable iff (!aresetn)
        given_reg |-> started_reg)
        else $error("result marked given before any item of the text");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && s_tlast |=> !started_reg && !given_reg && !ovf_reg && (pos_reg == '0)
                           && (bits_reg == '0))
        else $error("text state not cleared after end of text");

    a_ovf_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (pos_reg == {CNT_W{1'b1}}))
        else $error("overflow flag set below the position limit");

    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && emit |=> m_valid_reg)
        else $error("result lost on accept");

    a_no_shift_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        given_reg && !ctrl.clear |=> $stable(bits_reg))
        else $error("prefix bits moved after the result was given");
`endif

endmodule

// File: tb/first_substring_match_core_tb.sv
// testbench for the first substring match core: shift-and predictor, scoreboard, random texts
`timescale 1ns / 1ps

localparam int TB_MAX_PATTERN   = 16;
localparam int TB_POSITION_BITS = 16;
localparam int unsigned TB_POS_LIMIT =
    (TB_POSITION_BITS >= 16) ? 65535 : (1 << TB_POSITION_BITS) - 1;

typedef struct packed {
    logic [fsubm_pkg::POS_W-1:0] position;
    logic                        saturated;
} match_result_t;

class match_scoreboard;
    logic [fsubm_pkg::LEN_W-1:0] pattern_length;
    logic [63:0]                 pattern_low;
    logic [63:0]                 pattern_high;
    logic [TB_MAX_PATTERN-1:0]   prefix_bits;
    int unsigned                 char_index;
    bit                          result_out;
    bit                          overflowed;
    bit                          in_text;
    match_result_t               expected_q[$];
    int                          errors;
    int                          texts;
    int                          found;
    int                          misses;
    int                          saturated;

    function new();
        pattern_length = '0;
        pattern_low    = '0;
        pattern_high   = '0;
        errors         = 0;
        texts          = 0;
        found          = 0;
        misses         = 0;
        saturated      = 0;
        clear_text();
    endfunction

    function void clear_text();
        prefix_bits = '0;
        char_index  = 0;
        result_out  = 1'b0;
        overflowed  = 1'b0;
        in_text     = 1'b0;
    endfunction

    function void write_reg(input logic [fsubm_pkg::CFG_INDEX_W-1:0] index,
                            input logic [fsubm_pkg::CFG_DATA_W-1:0] value);
        case (index)
            fsubm_pkg::REG_PATTERN_LENGTH: pattern_length = value[fsubm_pkg::LEN_W-1:0];
            fsubm_pkg::REG_PATTERN_LOW:    pattern_low    = value;
            fsubm_pkg::REG_PATTERN_HIGH:   pattern_high   = value;
            default: ;
        endcase
    endfunction

    function void expect_result(input logic [fsubm_pkg::POS_W-1:0] position);
        match_result_t r;
        r.position  = position;
        r.saturated = overflowed;
        expected_q.push_back(r);
        if (position == fsubm_pkg::NO_MATCH) misses++;
        else found++;
        if (overflowed) saturated++;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // shift-and step for one accepted request
    function void note_request(input logic [7:0] text_byte, input logic has_char,
                               input logic end_of_text);
        int unsigned               m;
        int unsigned               idx;
        int unsigned               start;
        logic [TB_MAX_PATTERN-1:0] hits;
        logic [7:0]                pc;
        bit                        first_item;
        m = pattern_length;
        if (m > 16) m = 16;
        if (m > TB_MAX_PATTERN) m = TB_MAX_PATTERN;
        first_item = !in_text;
        in_text = 1'b1;
        if (!result_out) begin
            if (m == 0) begin
                if (first_item) begin
                    expect_result('0);
                    result_out = 1'b1;
                end
            end else if (has_char) begin
                idx = char_index;
                if (idx >= TB_POS_LIMIT) begin
                    idx = TB_POS_LIMIT;
                    overflowed = 1'b1;
                end else begin
                    char_index = idx + 1;
                end
                hits = '0;
                for (int j = 0; j < m; j++) begin
                    if (j < 8) pc = pattern_low[j*8 +: 8];
                    else pc = pattern_high[(j-8)*8 +: 8];
                    if (pc == text_byte) hits[j] = 1'b1;
                end
                prefix_bits = {prefix_bits[TB_MAX_PATTERN-2:0], 1'b1} & hits;
                if (prefix_bits[m-1]) begin
                    start = (idx >= m - 1) ? idx - (m - 1) : 0;
                    expect_result(start[fsubm_pkg::POS_W-1:0]);
                    result_out = 1'b1;
                end
            end
            if (end_of_text && !result_out) expect_result(fsubm_pkg::NO_MATCH);
        end
        if (end_of_text) begin
            texts++;
            clear_text();
        end
    endfunction

    function void check_result(input logic [fsubm_pkg::M_TDATA_W-1:0] tdata,
                               input logic tuser);
        match_result_t want;
        if (expected_q.size() == 0) begin
            $error("result with nothing pending: match_position %0d",
                   $signed(tdata[fsubm_pkg::POS_W-1:0]));
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (tdata[fsubm_pkg::POS_W-1:0] !== want.position) begin
            $error("match_position: expected %0d, actual %0d", $signed(want.position),
                   $signed(tdata[fsubm_pkg::POS_W-1:0]));
            errors++;
        end
        if (tuser !== want.saturated) begin
            $error("position_saturated: expected %0b, actual %0b", want.saturated, tuser);
            errors++;
        end
    endfunction
endclass

module first_substring_match_core_tb;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                cfg_we    = 1'b0;
    logic [fsubm_pkg::CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [fsubm_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [7:0]                          s_tdata   = '0;   // [7:0] text_byte
    logic                                s_tuser   = 1'b0; // [0] has_char
    logic                                s_tlast   = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [fsubm_pkg::M_TDATA_W-1:0]     m_tdata;          // [16:0] match_position
    logic                                m_tuser;          // [0] position_saturated

    match_scoreboard sb = new();

    bit          gaps_on   = 1'b1;
    bit          stalls_on = 1'b1;
    int          request_count = 0;
    int unsigned eff_len = 0;
    logic [7:0]  pat_chars[16];
    int          alpha_base = 0;
    int          alpha_size = 256;

    first_substring_match_core #(
        .MAX_PATTERN  (TB_MAX_PATTERN),
        .POSITION_BITS(TB_POSITION_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // result side: check every accepted result, stall in random bursts
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (stalls_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 14);
            end
        end
    end

    task automatic send_request(input logic [7:0] text_byte, input logic has_char,
                                input logic end_of_text);
        int gap;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= text_byte;
        s_tuser  <= has_char;
        s_tlast  <= end_of_text;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(text_byte, has_char, end_of_text);
        request_count++;
    endtask

    // hold off the sender until every pending result is out and the core has settled
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_config(input logic [fsubm_pkg::LEN_W-1:0] len,
                                input logic [63:0] low, input logic [63:0] high);
        cfg_we    <= 1'b1;
        cfg_index <= fsubm_pkg::REG_PATTERN_LENGTH;
        cfg_wdata <= {{(fsubm_pkg::CFG_DATA_W-fsubm_pkg::LEN_W){1'b0}}, len};
        sb.write_reg(fsubm_pkg::REG_PATTERN_LENGTH,
                     {{(fsubm_pkg::CFG_DATA_W-fsubm_pkg::LEN_W){1'b0}}, len});
        @(posedge aclk);
        cfg_index <= fsubm_pkg::REG_PATTERN_LOW;
        cfg_wdata <= low;
        sb.write_reg(fsubm_pkg::REG_PATTERN_LOW, low);
        @(posedge aclk);
        cfg_index <= fsubm_pkg::REG_PATTERN_HIGH;
        cfg_wdata <= high;
        sb.write_reg(fsubm_pkg::REG_PATTERN_HIGH, high);
        @(posedge aclk);
        cfg_we <= 1'b0;
        eff_len = (len > 16) ? 16 : len;
        for (int k = 0; k < 16; k++) begin
            if (k < 8) pat_chars[k] = low[k*8 +: 8];
            else pat_chars[k] = high[(k-8)*8 +: 8];
        end
    endtask

    // random text over the current alphabet, often with the pattern planted in it
    task automatic send_random_text();
        logic [7:0] body[$];
        int         len;
        int         off;
        bit         sep_end;
        if ($urandom_range(0, 19) == 0) begin
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            return;
        end
        len = $urandom_range(1, 2 * eff_len + 10);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 85)
                body.push_back(8'(alpha_base + $urandom_range(0, alpha_size - 1)));
            else
                body.push_back(8'($urandom_range(0, 255)));
        end
        if (eff_len > 0 && len >= eff_len && $urandom_range(0, 9) < 5) begin
            off = $urandom_range(0, len - eff_len);
            for (int j = 0; j < eff_len; j++) body[off + j] = pat_chars[j];
        end
        sep_end = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 29) == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_request(body[i], 1'b1, (i == len - 1) && !sep_end);
        end
        if (sep_end) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic run_random_phase(input int n_items);
        int                            target;
        int                            sel;
        logic [fsubm_pkg::LEN_W-1:0]   len;
        logic [127:0]                  chars;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       len = '0;
            1:       len = (fsubm_pkg::LEN_W)'(16);
            2:       len = (fsubm_pkg::LEN_W)'($urandom_range(17, 31));
            3:       len = (fsubm_pkg::LEN_W)'(1);
            4:       len = (fsubm_pkg::LEN_W)'($urandom_range(2, 3));
            default: len = (fsubm_pkg::LEN_W)'($urandom_range(1, 16));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            alpha_base = 0;
            alpha_size = 256;
        end else begin
            alpha_size = $urandom_range(2, 4);
            alpha_base = $urandom_range(0, 256 - alpha_size);
        end
        for (int k = 0; k < 16; k++)
            chars[k*8 +: 8] = 8'(alpha_base + $urandom_range(0, alpha_size - 1));
        write_config(len, chars[63:0], chars[127:64]);
        target = request_count + n_items;
        while (request_count < target) send_random_text();
        wait_drained();
    endtask

    initial begin : stimulus
        int random_start;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // overlapping candidate: "aab" inside "aaab", with a no-character item mid-text
        write_config(5'd3, 64'h0000_0000_0062_6161, 64'h0);
        send_request("a", 1'b1, 1'b0);
        send_request("a", 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b0);
        send_request("a", 1'b1, 1'b0);
        send_request("b", 1'b1, 1'b1);
        send_request(8'hFF, 1'b0, 1'b1);        // empty text
        send_request("a", 1'b1, 1'b0);
        send_request("a", 1'b1, 1'b0);
        send_request("b", 1'b1, 1'b0);
        send_request("q", 1'b1, 1'b0);          // ignored after the match
        send_request(8'h00, 1'b0, 1'b1);
        wait_drained();

        // empty pattern
        write_config(5'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request("z", 1'b1, 1'b1);
        send_request(8'h00, 1'b0, 1'b1);
        wait_drained();

        // oversized length clamps to the full 16 characters
        write_config(5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        for (int i = 0; i < 16; i++) send_request((i < 8) ? 8'hFF : 8'h00, 1'b1, i == 15);
        wait_drained();

        random_start = request_count;
        while (request_count - random_start < 1700) run_random_phase($urandom_range(100, 250));

        // closing stretch at full rate on both sides
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_random_phase(300);
        repeat (16) @(posedge aclk);

        $display("covered %0d texts in %0d requests: %0d matches, %0d without match",
                 sb.texts, request_count, sb.found, sb.misses);
        $display("%0d results with a saturated position counter", sb.saturated);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
